>>> src/swc_pkg.sv
package swc_pkg;

   // Store sizes
   localparam int MAX_BINS      = 1024;
   localparam int MAX_WIDTH     = 1024;
   localparam int MAX_HEIGHT    = 512;
   localparam int PALETTE_DEPTH = 256;

   // Field and register widths
   localparam int BIN_AW   = $clog2(MAX_BINS);
   localparam int CNT_W    = BIN_AW + 1;
   localparam int PAL_AW   = $clog2(PALETTE_DEPTH);
   localparam int COL_W    = 10;
   localparam int ROW_W    = 9;
   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 10;
   localparam int LEVEL_W  = 16;
   localparam int COLOR_W  = 16;
   localparam int IDX_W    = 8;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 16;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 48;

   // Shared restoring divider
   localparam int DIV_Q_W = 24;
   localparam int DIV_R_W = 17;
   localparam int PROD_W  = COL_W + CNT_W;
   localparam int STEP_W  = 5;
   localparam logic [STEP_W-1:0] BIN_DIV_STEPS = STEP_W'(PROD_W);
   localparam logic [STEP_W-1:0] IDX_DIV_STEPS = STEP_W'(IDX_W);

   // Actions carried in tuser
   localparam logic [1:0] ACT_PALETTE = 2'd0;
   localparam logic [1:0] ACT_BIN     = 2'd1;
   localparam logic [1:0] ACT_PIXEL   = 2'd2;

   // Register indexes
   localparam logic [CSR_AW-1:0] REG_LEVEL_MIN   = 2'd0;
   localparam logic [CSR_AW-1:0] REG_LEVEL_MAX   = 2'd1;
   localparam logic [CSR_AW-1:0] REG_LINE_WIDTH  = 2'd2;
   localparam logic [CSR_AW-1:0] REG_LINE_HEIGHT = 2'd3;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic bin_read;
      logic idx_prep;
      logic pal_read;
      logic out_pixel;
      logic out_commit;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic need_div;
      logic out_free;
   } stat_type;

endpackage

>>> src/swc_ram.sv
module swc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/swc_ctrl.sv
module swc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [1:0]         req_tuser,
   input  logic               req_tlast,
   input  swc_pkg::stat_type  stat,
   output swc_pkg::cmd_type   cmd
);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_BDIV = 8'b0000_0010,
      S_BRD  = 8'b0000_0100,
      S_PREP = 8'b0000_1000,
      S_IDIV = 8'b0001_0000,
      S_PRD  = 8'b0010_0000,
      S_PIX  = 8'b0100_0000,
      S_CMT  = 8'b1000_0000
   } state_type;

   state_type                    state_ff, state_in;
   logic [swc_pkg::STEP_W-1:0]   step_ff, step_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               case (req_tuser)
                  swc_pkg::ACT_BIN: begin
                     if (req_tlast) begin
                        state_in = S_CMT;
                     end
                  end
                  swc_pkg::ACT_PIXEL: begin
                     if (stat.count_zero) begin
                        state_in = S_PIX;
                     end else begin
                        state_in = S_BDIV;
                        step_in  = swc_pkg::BIN_DIV_STEPS;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_BDIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - 1'b1;
            if (step_ff == swc_pkg::STEP_W'(1)) begin
               state_in = S_BRD;
            end
         end
         S_BRD: begin
            cmd.bin_read = 1'b1;
            state_in     = S_PREP;
         end
         S_PREP: begin
            cmd.idx_prep = 1'b1;
            if (stat.need_div) begin
               state_in = S_IDIV;
               step_in  = swc_pkg::IDX_DIV_STEPS;
            end else begin
               state_in = S_PRD;
            end
         end
         S_IDIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - 1'b1;
            if (step_ff == swc_pkg::STEP_W'(1)) begin
               state_in = S_PRD;
            end
         end
         S_PRD: begin
            cmd.pal_read = 1'b1;
            state_in     = S_PIX;
         end
         S_PIX: begin
            // hold the word until the output register frees up
            if (stat.out_free) begin
               cmd.out_pixel = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_CMT: begin
            if (stat.out_free) begin
               cmd.out_commit = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

>>> src/swc_datapath.sv
module swc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  swc_pkg::cmd_type                    cmd,
   output swc_pkg::stat_type                   stat,
   input  logic [1:0]                          req_tuser,
   input  logic                                req_tlast,
   input  logic [swc_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                csr_we,
   input  logic [swc_pkg::CSR_AW-1:0]          csr_index,
   input  logic [swc_pkg::CSR_DW-1:0]          csr_wdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [swc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tuser
);

   // Request fields
   logic [swc_pkg::PAL_AW-1:0]    req_slot;
   logic [swc_pkg::COLOR_W-1:0]   req_color;
   logic [swc_pkg::LEVEL_W-1:0]   req_level;
   logic [swc_pkg::COL_W-1:0]     req_col;

   assign req_slot  = req_tdata[7:0];
   assign req_color = req_tdata[23:8];
   assign req_level = req_tdata[39:24];
   assign req_col   = req_tdata[49:40];

   // Configuration
   logic signed [swc_pkg::LEVEL_W-1:0]  level_min_ff, level_min_in;
   logic signed [swc_pkg::LEVEL_W-1:0]  level_max_ff, level_max_in;
   logic [swc_pkg::WIDTH_W-1:0]         line_width_ff, line_width_in;
   logic [swc_pkg::HEIGHT_W-1:0]        line_height_ff, line_height_in;

   // Line and ring state
   logic                          loaded_ff, loaded_in;
   logic [swc_pkg::CNT_W-1:0]     ptr_ff, ptr_in;
   logic [swc_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [swc_pkg::ROW_W-1:0]     row_ff, row_in;

   // Pixel work registers
   logic [swc_pkg::COL_W-1:0]     col_ff, col_in;
   logic                          zero_ff, zero_in;
   logic                          use_div_ff, use_div_in;
   logic [swc_pkg::IDX_W-1:0]     sat_ff, sat_in;
   logic [swc_pkg::IDX_W-1:0]     idx_ff, idx_in;

   // Divider
   logic [swc_pkg::DIV_Q_W-1:0]   quo_ff, quo_in;
   logic [swc_pkg::DIV_R_W-1:0]   rem_ff, rem_in;
   logic [swc_pkg::DIV_R_W-1:0]   dvs_ff, dvs_in;

   // Output register
   logic                          out_valid_ff, out_valid_in;
   logic [swc_pkg::RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                          out_user_ff, out_user_in;

   // Combinational helpers
   logic                          acc_pal, acc_bin, acc_pix;
   logic                          bin_room;
   logic [swc_pkg::CNT_W-1:0]     ptr_next;
   logic [swc_pkg::WIDTH_W-1:0]   width_eff;
   logic [swc_pkg::HEIGHT_W-1:0]  height_eff;
   logic [swc_pkg::HEIGHT_W-1:0]  row_inc;
   logic [swc_pkg::PROD_W-1:0]    prod;
   logic [swc_pkg::DIV_R_W:0]     rem_sh;
   logic [swc_pkg::DIV_R_W:0]     rem_diff;
   logic                          qbit;
   logic                          bin_over;
   logic [swc_pkg::BIN_AW-1:0]    bin_sel;
   logic signed [swc_pkg::LEVEL_W-1:0] level_d;
   logic signed [swc_pkg::LEVEL_W:0]   num;
   logic signed [swc_pkg::LEVEL_W:0]   den;
   logic                          inverted;
   logic [swc_pkg::DIV_Q_W-1:0]   scaled;
   logic [swc_pkg::IDX_W-1:0]     idx_pick;
   logic [swc_pkg::COLOR_W-1:0]   color_out;

   // Memory ports
   logic                          bin_we, bin_re;
   logic [swc_pkg::BIN_AW-1:0]    bin_addr;
   logic [swc_pkg::LEVEL_W-1:0]   bin_rdata;
   logic                          pal_we, pal_re;
   logic [swc_pkg::PAL_AW-1:0]    pal_addr;
   logic [swc_pkg::COLOR_W-1:0]   pal_rdata;

   assign acc_pal = cmd.accept && (req_tuser == swc_pkg::ACT_PALETTE);
   assign acc_bin = cmd.accept && (req_tuser == swc_pkg::ACT_BIN);
   assign acc_pix = cmd.accept && (req_tuser == swc_pkg::ACT_PIXEL);

   // Zero acts as one, large values saturate
   always_comb begin
      if (line_width_ff == '0) begin
         width_eff = swc_pkg::WIDTH_W'(1);
      end else if (line_width_ff > swc_pkg::WIDTH_W'(swc_pkg::MAX_WIDTH)) begin
         width_eff = swc_pkg::WIDTH_W'(swc_pkg::MAX_WIDTH);
      end else begin
         width_eff = line_width_ff;
      end
      if (line_height_ff == '0) begin
         height_eff = swc_pkg::HEIGHT_W'(1);
      end else if (line_height_ff > swc_pkg::HEIGHT_W'(swc_pkg::MAX_HEIGHT)) begin
         height_eff = swc_pkg::HEIGHT_W'(swc_pkg::MAX_HEIGHT);
      end else begin
         height_eff = line_height_ff;
      end
   end

   assign bin_room = (ptr_ff < swc_pkg::CNT_W'(swc_pkg::MAX_BINS));
   assign ptr_next = bin_room ? ptr_ff + 1'b1 : ptr_ff;
   assign row_inc  = swc_pkg::HEIGHT_W'(row_ff) + 1'b1;
   assign prod     = swc_pkg::PROD_W'(req_col) * swc_pkg::PROD_W'(count_ff);

   // One restoring step
   assign rem_sh   = {rem_ff, quo_ff[swc_pkg::DIV_Q_W-1]};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};
   assign qbit     = (rem_sh >= {1'b0, dvs_ff});

   // Bin index saturates to count-1
   assign bin_over = (quo_ff[swc_pkg::PROD_W-1:0] >= swc_pkg::PROD_W'(count_ff));
   assign bin_sel  = bin_over ? swc_pkg::BIN_AW'(count_ff - 1'b1)
                              : quo_ff[swc_pkg::BIN_AW-1:0];

   // Level to index
   assign level_d  = bin_rdata;
   assign num      = {level_d[swc_pkg::LEVEL_W-1], level_d}
                   - {level_min_ff[swc_pkg::LEVEL_W-1], level_min_ff};
   assign den      = {level_max_ff[swc_pkg::LEVEL_W-1], level_max_ff}
                   - {level_min_ff[swc_pkg::LEVEL_W-1], level_min_ff};
   assign inverted = (level_max_ff <= level_min_ff);
   // num * 255 as a shift and subtract
   assign scaled   = {num[swc_pkg::LEVEL_W-1:0], 8'b0}
                   - {8'b0, num[swc_pkg::LEVEL_W-1:0]};

   assign idx_pick = use_div_ff ? quo_ff[swc_pkg::IDX_W-1:0] : sat_ff;
   assign color_out = (zero_ff || !loaded_ff) ? '0 : pal_rdata;

   always_comb begin
      stat.count_zero = (count_ff == '0);
      stat.need_div   = !inverted && (num > 0) && (num < den);
      stat.out_free   = !out_valid_ff || rsp_tready;
   end

   // Memory port control
   always_comb begin
      bin_we   = acc_bin && bin_room;
      bin_re   = cmd.bin_read;
      bin_addr = bin_we ? ptr_ff[swc_pkg::BIN_AW-1:0] : bin_sel;
      pal_we   = acc_pal;
      pal_re   = cmd.pal_read;
      pal_addr = pal_we ? req_slot : idx_pick;
   end

   always_comb begin
      level_min_in   = level_min_ff;
      level_max_in   = level_max_ff;
      line_width_in  = line_width_ff;
      line_height_in = line_height_ff;
      if (csr_we) begin
         case (csr_index)
            swc_pkg::REG_LEVEL_MIN:   level_min_in   = csr_wdata;
            swc_pkg::REG_LEVEL_MAX:   level_max_in   = csr_wdata;
            swc_pkg::REG_LINE_WIDTH:  line_width_in  = csr_wdata[swc_pkg::WIDTH_W-1:0];
            swc_pkg::REG_LINE_HEIGHT: line_height_in = csr_wdata[swc_pkg::HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      loaded_in = loaded_ff || acc_pal;
      ptr_in    = ptr_ff;
      count_in  = count_ff;
      row_in    = row_ff;
      if (acc_bin) begin
         if (req_tlast) begin
            // commit the line and advance the ring
            count_in = ptr_next;
            ptr_in   = '0;
            row_in   = (row_inc < height_eff) ? swc_pkg::ROW_W'(row_inc) : '0;
         end else begin
            ptr_in = ptr_next;
         end
      end
   end

   always_comb begin
      col_in     = col_ff;
      zero_in    = zero_ff;
      use_div_in = use_div_ff;
      sat_in     = sat_ff;
      idx_in     = idx_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      dvs_in     = dvs_ff;
      if (acc_pix) begin
         col_in  = req_col;
         zero_in = (count_ff == '0);
         idx_in  = '0;
         quo_in  = {prod, (swc_pkg::DIV_Q_W - swc_pkg::PROD_W)'(0)};
         rem_in  = '0;
         dvs_in  = swc_pkg::DIV_R_W'(width_eff);
      end
      if (cmd.div_step) begin
         quo_in = {quo_ff[swc_pkg::DIV_Q_W-2:0], qbit};
         rem_in = qbit ? rem_diff[swc_pkg::DIV_R_W-1:0] : rem_sh[swc_pkg::DIV_R_W-1:0];
      end
      if (cmd.idx_prep) begin
         use_div_in = stat.need_div;
         if (inverted) begin
            sat_in = (level_d > level_min_ff) ? '1 : '0;
         end else begin
            sat_in = (num > 0) ? '1 : '0;
         end
         // quotient fits 8 bits, so the top bits preload the remainder
         rem_in = swc_pkg::DIV_R_W'(scaled[swc_pkg::DIV_Q_W-1:swc_pkg::IDX_W]);
         quo_in = {scaled[swc_pkg::IDX_W-1:0], (swc_pkg::DIV_Q_W - swc_pkg::IDX_W)'(0)};
         dvs_in = den;
      end
      if (cmd.pal_read) begin
         idx_in = idx_pick;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      if (cmd.out_pixel) begin
         out_valid_in = 1'b1;
         out_user_in  = 1'b0;
         out_data_in  = {5'b0, row_ff, color_out, idx_ff, col_ff};
      end else if (cmd.out_commit) begin
         out_valid_in = 1'b1;
         out_user_in  = 1'b1;
         out_data_in  = {5'b0, row_ff, swc_pkg::COLOR_W'(0), swc_pkg::IDX_W'(0),
                         swc_pkg::COL_W'(0)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_min_ff   <= -16'sd10240;
         level_max_ff   <= '0;
         line_width_ff  <= swc_pkg::WIDTH_W'(800);
         line_height_ff <= swc_pkg::HEIGHT_W'(100);
         loaded_ff      <= 1'b0;
         ptr_ff         <= '0;
         count_ff       <= '0;
         row_ff         <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         level_min_ff   <= level_min_in;
         level_max_ff   <= level_max_in;
         line_width_ff  <= line_width_in;
         line_height_ff <= line_height_in;
         loaded_ff      <= loaded_in;
         ptr_ff         <= ptr_in;
         count_ff       <= count_in;
         row_ff         <= row_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      zero_ff     <= zero_in;
      use_div_ff  <= use_div_in;
      sat_ff      <= sat_in;
      idx_ff      <= idx_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   swc_ram #(
      .WIDTH (swc_pkg::LEVEL_W),
      .DEPTH (swc_pkg::MAX_BINS)
   ) u_bin_ram (
      .clock (clock),
      .wr_en (bin_we),
      .rd_en (bin_re),
      .addr  (bin_addr),
      .wdata (req_level),
      .rdata (bin_rdata)
   );

   swc_ram #(
      .WIDTH (swc_pkg::COLOR_W),
      .DEPTH (swc_pkg::PALETTE_DEPTH)
   ) u_pal_ram (
      .clock (clock),
      .wr_en (pal_we),
      .rd_en (pal_re),
      .addr  (pal_addr),
      .wdata (req_color),
      .rdata (pal_rdata)
   );

endmodule

>>> src/spectrum_waterfall_colormap.sv
// Waterfall colormap: turns spectrum bins into display pixel colors.
// Request channel (req_*): tuser selects palette write, spectrum bin or pixel
// request; tlast on a bin closes and commits the current line.
// Response channel (rsp_*): one word per committed line (tuser high, newest
// ring row) and one word per pixel request (column, palette index, color).
// Palette writes and bins that do not close a line produce no response.
// Configuration (csr_*): level range, line width and ring height; the user
// writes them only while the block is idle (not enforced); no read-back.
// Timing: palette writes and bins are stored as they are accepted. A commit
// passes through the commit state into the output register. A pixel makes a
// 21-step pass through the shared one-bit-per-cycle divider for the bin,
// then an 8-step pass unless the level falls outside the range and saturates;
// with no committed line it skips both. One word is handled at a time.
// A result sits in the output register until taken, so the next request is
// accepted while the receiver stalls; a later result waits for that register.
// Reset clears the ring row, bin count, write pointer and palette flag and
// loads default levels and geometry; palette and bin memories are not cleared.
module spectrum_waterfall_colormap (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] palette_slot, [23:8] color_word, [39:24] bin_level,
   // [49:40] pixel_column, [55:50] zero
   input  logic [swc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [1:0] action
   input  logic [1:0]                          req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [9:0] out_column, [17:10] color_index, [33:18] pixel_color,
   // [42:34] newest_row, [47:43] zero
   output logic [swc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [0] line_committed
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [swc_pkg::CSR_AW-1:0]          csr_index,
   input  logic [swc_pkg::CSR_DW-1:0]          csr_wdata
);

   swc_pkg::cmd_type   cmd;
   swc_pkg::stat_type  stat;

   swc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .stat       (stat),
      .cmd        (cmd)
   );

   swc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
